FILE: src/cube_sphere_face_vertex_gen_macros.svh
// assertion macros used by the checker file
`ifndef CUBE_SPHERE_FACE_VERTEX_GEN_MACROS_SVH
`define CUBE_SPHERE_FACE_VERTEX_GEN_MACROS_SVH

// property that holds at every clock edge, reset included
`define CSSF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// property that is checked only out of reset
`define CSSF_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

FILE: src/cssf_pkg.sv
// shared types and constants of the cube sphere face vertex generator
package cssf_pkg;

  localparam int GRID_W     = 8;
  localparam int RES_W      = 9;
  localparam int UP_W       = 16;
  localparam int B_W        = 33;
  localparam int NORM_W     = 16;
  localparam int NORM_MSB   = 15;
  localparam int SQ_W       = 32;
  localparam int SUM_W      = 34;
  localparam int IDX_W      = 16;
  localparam int POS_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int RES_MIN    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UP_X       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UP_Y       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UP_Z       = 2'd3;

  localparam logic [RES_W-1:0] RESOLUTION_RESET = 9'd2;
  localparam logic [UP_W-1:0]  UP_X_RESET       = 16'd0;
  localparam logic [UP_W-1:0]  UP_Y_RESET       = 16'd16384;
  localparam logic [UP_W-1:0]  UP_Z_RESET       = 16'd0;

  localparam logic [POS_W-1:0] POS_MAX = 16'h7FFF;

  // pipeline depth: front end, divider, root extraction, output format
  localparam int PRE_STAGES  = 8;
  localparam int DIV_STAGES  = 33;
  localparam int SQRT_STAGES = 17;
  localparam int UNIT_LAT    = DIV_STAGES + SQRT_STAGES + 1;

  typedef struct packed {
    logic neg;
    logic zero;
  } cssf_flags_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] quad;
    logic             has_quad;
    logic [IDX_W-1:0] idx_p1;
    logic [IDX_W-1:0] idx_pr;
    logic [IDX_W-1:0] idx_pr1;
  } cssf_meta_t;

endpackage

FILE: src/cssf_root_div.sv
// pipelined divide and square root giving one normalized sphere component
module cssf_root_div import cssf_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SQ_W-1:0]   num,
  input  logic [SUM_W-1:0]  den,
  input  cssf_flags_t       flags_in,
  output logic [POS_W-1:0]  pos
);

  localparam int REM_W = SUM_W + 1;
  localparam int QUO_W = DIV_STAGES;
  localparam int T_W   = 2 * SQRT_STAGES;
  localparam int RT_W  = SQRT_STAGES + 3;

  logic [REM_W-1:0]       dr_r [DIV_STAGES];
  logic [QUO_W-1:0]       dq_r [DIV_STAGES];
  logic [SUM_W-1:0]       dd_r [DIV_STAGES];
  cssf_flags_t            df_r [DIV_STAGES];

  logic [RT_W-1:0]        sr_r [SQRT_STAGES];
  logic [SQRT_STAGES-1:0] so_r [SQRT_STAGES];
  logic [T_W-1:0]         st_r [SQRT_STAGES];
  cssf_flags_t            sf_r [SQRT_STAGES];

  logic [POS_W-1:0]       pos_r;
  logic [POS_W-1:0]       pos_nxt;

  // restoring division, one quotient bit per stage, numerator is num * 2^32
  genvar k;
  generate
    for (k = 0; k < DIV_STAGES; k++) begin : g_div
      logic [REM_W-1:0] cur;
      logic [SUM_W-1:0] dv;
      logic [QUO_W-1:0] qin;
      cssf_flags_t      fin;
      logic             take;
      if (k == 0) begin : g_first
        assign cur = REM_W'(num);
        assign dv  = den;
        assign qin = '0;
        assign fin = flags_in;
      end else begin : g_next
        assign cur = {dr_r[k-1][REM_W-2:0], 1'b0};
        assign dv  = dd_r[k-1];
        assign qin = dq_r[k-1];
        assign fin = df_r[k-1];
      end
      assign take = cur >= REM_W'(dv);
      always_ff @(posedge clk) begin
        if (en) begin
          dr_r[k] <= take ? (cur - REM_W'(dv)) : cur;
          dq_r[k] <= {qin[QUO_W-2:0], take};
          dd_r[k] <= dv;
          df_r[k] <= fin;
        end
      end
    end
  endgenerate

  // digit by digit square root, two radicand bits per stage
  genvar j;
  generate
    for (j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
      logic [RT_W-1:0]        rin;
      logic [SQRT_STAGES-1:0] oin;
      logic [T_W-1:0]         tin;
      cssf_flags_t            fin;
      logic [RT_W-1:0]        cur;
      logic [RT_W-1:0]        trial;
      logic                   take;
      if (j == 0) begin : g_first
        assign rin = '0;
        assign oin = '0;
        assign tin = T_W'(dq_r[DIV_STAGES-1]);
        assign fin = df_r[DIV_STAGES-1];
      end else begin : g_next
        assign rin = sr_r[j-1];
        assign oin = so_r[j-1];
        assign tin = st_r[j-1];
        assign fin = sf_r[j-1];
      end
      assign cur   = {rin[RT_W-3:0], tin[T_W-1:T_W-2]};
      assign trial = RT_W'({oin, 2'b01});
      assign take  = cur >= trial;
      always_ff @(posedge clk) begin
        if (en) begin
          sr_r[j] <= take ? (cur - trial) : cur;
          so_r[j] <= {oin[SQRT_STAGES-2:0], take};
          st_r[j] <= {tin[T_W-3:0], 2'b00};
          sf_r[j] <= fin;
        end
      end
    end
  endgenerate

  // round half up, then force zero, negate negative values or saturate positive ones
  logic [SQRT_STAGES:0]   rnd;
  logic [SQRT_STAGES-1:0] q;
  logic [SQRT_STAGES-1:0] q_neg;
  cssf_flags_t            fl;

  always_comb begin
    rnd   = (SQRT_STAGES + 1)'(so_r[SQRT_STAGES-1]) + 1'b1;
    q     = rnd[SQRT_STAGES:1];
    q_neg = '0 - q;
    fl    = sf_r[SQRT_STAGES-1];
    if (fl.zero) begin
      pos_nxt = '0;
    end else if (fl.neg) begin
      pos_nxt = q_neg[POS_W-1:0];
    end else if (q > SQRT_STAGES'(POS_MAX)) begin
      pos_nxt = POS_MAX;
    end else begin
      pos_nxt = q[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_r <= pos_nxt;
    end
  end

  assign pos = pos_r;

endmodule

FILE: src/cube_sphere_face_vertex_gen.sv
// 59 register stages: 8 front, 33 divider, 17 root, 1 output
// throughput: one item per cycle; a stall at the output freezes the whole pipe
// the per-bit divider and root pipelines set the depth
// reset: synchronous, active low; clears all valid bits and loads the
// configuration defaults (resolution 2, up vector 0, 1.0, 0)
module cube_sphere_face_vertex_gen import cssf_pkg::*; #(
  parameter int MAX_RESOLUTION = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // grid_x, grid_y
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [175:0]          out_tdata,  // vertex_index, pos_x, pos_y, pos_z, quad_number,
                                            // tri0_a, tri0_b, tri0_c, tri1_a, tri1_b, tri1_c
  output logic                  out_tuser,  // has_quad
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DW  = $clog2(MAX_RESOLUTION);
  localparam int RW  = $clog2(MAX_RESOLUTION + 1);
  localparam int NW  = ((DW > GRID_W) ? DW : GRID_W) + 2;
  localparam int TUW = DW + 1 + UP_W;
  localparam int TAW = NW + UP_W;
  localparam int TBW = NW + B_W;
  localparam int PW  = NW + B_W + 2;
  localparam int LW  = $clog2(PW);
  localparam int NST = PRE_STAGES + UNIT_LAT;

  // configuration
  logic [RES_W-1:0]       resolution_r;
  logic signed [UP_W-1:0] up_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resolution_r <= RESOLUTION_RESET;
      up_r[0]      <= UP_X_RESET;
      up_r[1]      <= UP_Y_RESET;
      up_r[2]      <= UP_Z_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RESOLUTION: resolution_r <= cfg_data[RES_W-1:0];
        REG_UP_X:       up_r[0]      <= cfg_data[UP_W-1:0];
        REG_UP_Y:       up_r[1]      <= cfg_data[UP_W-1:0];
        REG_UP_Z:       up_r[2]      <= cfg_data[UP_W-1:0];
      endcase
    end
  end

  logic en;
  logic [NST-1:0] v_r;

  assign en        = !v_r[NST-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_tvalid};
    end
  end

  // stage 0: clamp, offsets, second axis, indices
  logic [GRID_W-1:0]        gx;
  logic [GRID_W-1:0]        gy;
  logic [RW-1:0]            res_c;
  logic [DW-1:0]            d_c;
  logic signed [B_W-1:0]    b_nxt [3];
  logic signed [NW-1:0]     nx_nxt;
  logic signed [NW-1:0]     ny_nxt;
  cssf_meta_t               meta_nxt;
  logic [IDX_W-1:0]         idx_c;
  logic                     has_c;

  always_comb begin
    gx = in_tdata[GRID_W-1:0];
    gy = in_tdata[2*GRID_W-1:GRID_W];
    if (resolution_r < RES_W'(RES_MIN)) begin
      res_c = RW'(RES_MIN);
    end else if (32'(resolution_r) > MAX_RESOLUTION) begin
      res_c = RW'(MAX_RESOLUTION);
    end else begin
      res_c = RW'(resolution_r);
    end
    d_c    = DW'(res_c - RW'(1));
    nx_nxt = $signed(NW'({gx, 1'b0})) - $signed(NW'(d_c));
    ny_nxt = $signed(NW'({gy, 1'b0})) - $signed(NW'(d_c));
    // up x A with A = (uy, uz, ux)
    b_nxt[0] = up_r[1] * up_r[0] - up_r[2] * up_r[2];
    b_nxt[1] = up_r[2] * up_r[1] - up_r[0] * up_r[0];
    b_nxt[2] = up_r[0] * up_r[2] - up_r[1] * up_r[1];
    idx_c = IDX_W'(gx) + IDX_W'(gy) * IDX_W'(res_c);
    has_c = (IDX_W'(gx) < IDX_W'(d_c)) && (IDX_W'(gy) < IDX_W'(d_c));
    meta_nxt.idx      = idx_c;
    meta_nxt.has_quad = has_c;
    if (has_c) begin
      meta_nxt.quad    = IDX_W'(gx) + IDX_W'(gy) * IDX_W'(d_c);
      meta_nxt.idx_p1  = idx_c + IDX_W'(1);
      meta_nxt.idx_pr  = idx_c + IDX_W'(res_c);
      meta_nxt.idx_pr1 = idx_c + IDX_W'(res_c) + IDX_W'(1);
    end else begin
      meta_nxt.quad    = '0;
      meta_nxt.idx_p1  = '0;
      meta_nxt.idx_pr  = '0;
      meta_nxt.idx_pr1 = '0;
    end
  end

  logic [DW-1:0]          d0_r;
  logic signed [NW-1:0]   nx0_r;
  logic signed [NW-1:0]   ny0_r;
  logic signed [UP_W-1:0] u0_r [3];
  logic signed [B_W-1:0]  b0_r [3];
  cssf_meta_t             meta_r [NST];

  always_ff @(posedge clk) begin
    if (en) begin
      d0_r  <= d_c;
      nx0_r <= nx_nxt;
      ny0_r <= ny_nxt;
      for (int c = 0; c < 3; c++) begin
        u0_r[c] <= up_r[c];
        b0_r[c] <= b_nxt[c];
      end
      meta_r[0] <= meta_nxt;
      for (int s = 1; s < NST; s++) begin
        meta_r[s] <= meta_r[s-1];
      end
    end
  end

  // stage 1: the nine products
  logic signed [TUW-1:0] tu1_r [3];
  logic signed [TAW-1:0] ta1_r [3];
  logic signed [TBW-1:0] tb1_r [3];
  logic signed [TUW-1:0] tu1_nxt [3];
  logic signed [TAW-1:0] ta1_nxt [3];
  logic signed [TBW-1:0] tb1_nxt [3];
  logic signed [DW:0]    d_s;

  always_comb begin
    d_s = $signed({1'b0, d0_r});
    for (int c = 0; c < 3; c++) begin
      tu1_nxt[c] = d_s * u0_r[c];
      tb1_nxt[c] = ny0_r * b0_r[c];
    end
    ta1_nxt[0] = nx0_r * u0_r[1];
    ta1_nxt[1] = nx0_r * u0_r[2];
    ta1_nxt[2] = nx0_r * u0_r[0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tu1_r <= tu1_nxt;
      ta1_r <= ta1_nxt;
      tb1_r <= tb1_nxt;
    end
  end

  // stage 2: cube point scaled by d * 2^28
  logic signed [PW-1:0] eu [3];
  logic signed [PW-1:0] ea [3];
  logic signed [PW-1:0] eb [3];
  logic signed [PW-1:0] p2_nxt [3];
  logic signed [PW-1:0] p2_r [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      eu[c]     = PW'(tu1_r[c]);
      ea[c]     = PW'(ta1_r[c]);
      eb[c]     = PW'(tb1_r[c]);
      p2_nxt[c] = (eu[c] <<< 14) + (ea[c] <<< 14) + eb[c];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_r <= p2_nxt;
    end
  end

  // stage 3: sign and magnitude
  logic [PW-1:0] mag3_nxt [3];
  logic [PW-1:0] mag3_r [3];
  logic          neg3_r [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mag3_nxt[c] = p2_r[c][PW-1] ? (PW'(0) - $unsigned(p2_r[c])) : $unsigned(p2_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag3_r <= mag3_nxt;
      for (int c = 0; c < 3; c++) begin
        neg3_r[c] <= p2_r[c][PW-1];
      end
    end
  end

  // stage 4: leading one of the largest magnitude
  logic [PW-1:0] or_c;
  logic [LW-1:0] msb_c;
  logic [PW-1:0] mag4_r [3];
  logic          neg4_r [3];
  logic [LW-1:0] msb4_r;
  logic          zero4_r;

  always_comb begin
    or_c  = mag3_r[0] | mag3_r[1] | mag3_r[2];
    msb_c = '0;
    for (int k = 0; k < PW; k++) begin
      if (or_c[k]) begin
        msb_c = LW'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag4_r  <= mag3_r;
      neg4_r  <= neg3_r;
      msb4_r  <= msb_c;
      zero4_r <= (or_c == '0);
    end
  end

  // stage 5: common shift so the largest lands in [2^15, 2^16)
  logic [NORM_W-1:0] nm5_nxt [3];
  logic [NORM_W-1:0] nm5_r [3];
  cssf_flags_t       fl5_r [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (msb4_r >= LW'(NORM_MSB)) begin
        nm5_nxt[c] = NORM_W'(mag4_r[c] >> (msb4_r - LW'(NORM_MSB)));
      end else begin
        nm5_nxt[c] = NORM_W'(mag4_r[c] << (LW'(NORM_MSB) - msb4_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm5_r <= nm5_nxt;
      for (int c = 0; c < 3; c++) begin
        fl5_r[c] <= '{neg: neg4_r[c], zero: zero4_r};
      end
    end
  end

  // stage 6: squares; stage 7: their sum
  logic [SQ_W-1:0]  sq6_r [3];
  cssf_flags_t      fl6_r [3];
  logic [SQ_W-1:0]  sq7_r [3];
  logic [SUM_W-1:0] s7_r;
  cssf_flags_t      fl7_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        sq6_r[c] <= SQ_W'(nm5_r[c]) * SQ_W'(nm5_r[c]);
      end
      fl6_r <= fl5_r;
      sq7_r <= sq6_r;
      s7_r  <= SUM_W'(sq6_r[0]) + SUM_W'(sq6_r[1]) + SUM_W'(sq6_r[2]);
      fl7_r <= fl6_r;
    end
  end

  logic [POS_W-1:0] pos [3];

  genvar gc;
  generate
    for (gc = 0; gc < 3; gc++) begin : g_comp
      cssf_root_div u_root_div (
        .clk      (clk),
        .en       (en),
        .num      (sq7_r[gc]),
        .den      (s7_r),
        .flags_in (fl7_r[gc]),
        .pos      (pos[gc])
      );
    end
  endgenerate

  cssf_meta_t mo;
  logic [IDX_W-1:0] corner;

  assign mo         = meta_r[NST-1];
  assign corner     = mo.has_quad ? mo.idx : '0;
  assign out_tvalid = v_r[NST-1];
  assign out_tuser  = mo.has_quad;
  assign out_tdata  = {mo.idx_pr1, mo.idx_p1, corner, mo.idx_pr, mo.idx_pr1, corner,
                       mo.quad, pos[2], pos[1], pos[0], mo.idx};

endmodule

FILE: src/cssf_chk.sv
// port-level checks of the vertex generator, bound to the top level
`include "cube_sphere_face_vertex_gen_macros.svh"
module cssf_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [175:0] out_tdata,
  input logic         out_tuser
);

  logic stalled;
  logic corners_ok;
  logic no_quad_fields;

  assign stalled        = out_tvalid && !out_tready;
  assign corners_ok     = (out_tdata[95:80] == out_tdata[15:0]) &&
                          (out_tdata[143:128] == out_tdata[15:0]) &&
                          (out_tdata[111:96] == out_tdata[175:160]);
  assign no_quad_fields = (out_tdata[175:64] == '0);

  `CSSF_ASSERT(a_rst_clears, !rst_n |=> !out_tvalid, "output valid after reset")
  `CSSF_ASSERT_RUN(a_stall_src, in_tready == (!out_tvalid || out_tready), "input stalled")
  `CSSF_ASSERT_RUN(a_hold, stalled |=> out_tvalid && $stable(out_tdata), "stalled item changed")
  `CSSF_ASSERT_RUN(a_corner, out_tvalid && out_tuser |-> corners_ok, "quad corners inconsistent")
  `CSSF_ASSERT_RUN(a_noquad, out_tvalid && !out_tuser |-> no_quad_fields, "quad fields set")

endmodule

bind cube_sphere_face_vertex_gen cssf_chk u_cssf_chk (.*);
